/* sv/dik_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dik_pkg;

  // Fractional bits of a millimetre in every length.
  localparam int FRAC_BITS = 8;

  localparam int IN_W   = 20;               // point coordinates
  localparam int STEP_W = 10;               // steps per mm
  localparam int LEN_W  = 19;               // tower height, arm, nozzle
  localparam int OFF_W  = 20;               // base offsets
  localparam int CFG_W  = 20;               // widest register
  localparam int IDX_W  = 3;
  localparam int M_W    = 2 * IN_W;         // one product
  localparam int D_W    = 44;               // root argument, signed
  localparam int R_W    = 42;               // root operand, even width
  localparam int S_W    = R_W / 2;          // integer square root
  localparam int Z_W    = 22;               // shifted z
  localparam int E_W    = 24;               // -z' - s
  localparam int P_W    = E_W + STEP_W + 1; // product with steps
  localparam int AX_W   = 32;               // axis in steps

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_STEPS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_ARM    = 3'd2;
  localparam logic [IDX_W-1:0] REG_NOZZLE = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFF_A  = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFF_B  = 3'd5;
  localparam logic [IDX_W-1:0] REG_OFF_C  = 3'd6;

  localparam logic [STEP_W-1:0] RST_STEPS  = 10'd80;
  localparam logic [LEN_W-1:0]  RST_HEIGHT = 19'd102400;
  localparam logic [LEN_W-1:0]  RST_ARM    = 19'd51200;

  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic [LEN_W-1:0]  height;
    logic [LEN_W-1:0]  arm;
    logic [LEN_W-1:0]  nozzle;
    logic [OFF_W-1:0]  off_a;
    logic [OFF_W-1:0]  off_b;
    logic [OFF_W-1:0]  off_c;
  } dik_cfg_t;

  // Root arguments of the three towers and the shifted z.
  typedef struct packed {
    logic [2:0][D_W-1:0] d;
    logic [Z_W-1:0]      zp;
  } dik_arg_t;

  // Roots of the three towers, shifted z and the out-of-reach flag.
  typedef struct packed {
    logic [2:0][S_W-1:0] root;
    logic [Z_W-1:0]      zp;
    logic                unr;
  } dik_root_t;

endpackage
`default_nettype wire

/* sv/dik_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
module dik_prep (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dik_pkg::dik_cfg_t           cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dik_pkg::IN_W-1:0]    pos_x,
  input  wire logic [dik_pkg::IN_W-1:0]    pos_y,
  input  wire logic [dik_pkg::IN_W-1:0]    pos_z,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dik_pkg::dik_arg_t                out_data
);
  import dik_pkg::*;

  logic                    v1_r, v2_r;
  logic                    rdy1, rdy2;
  logic signed [M_W-1:0]   xx_r, yy_r, ll_r, aa_r, bb_r, cc_r, ax_r, by_r, cy_r;
  logic signed [Z_W-1:0]   zp1_r;
  logic signed [D_W-1:0]   base, d1_nxt, d2_nxt, d3_nxt;
  dik_arg_t                arg_r;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // First stage: all products and the shift of z to the tower top.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      xx_r  <= $signed(pos_x) * $signed(pos_x);
      yy_r  <= $signed(pos_y) * $signed(pos_y);
      ll_r  <= $signed({1'b0, cfg.arm}) * $signed({1'b0, cfg.arm});
      aa_r  <= $signed(cfg.off_a) * $signed(cfg.off_a);
      bb_r  <= $signed(cfg.off_b) * $signed(cfg.off_b);
      cc_r  <= $signed(cfg.off_c) * $signed(cfg.off_c);
      ax_r  <= $signed(cfg.off_a) * $signed(pos_x);
      by_r  <= $signed(cfg.off_b) * $signed(pos_y);
      cy_r  <= $signed(cfg.off_c) * $signed(pos_y);
      zp1_r <= Z_W'($signed(pos_z)) + Z_W'($signed(cfg.nozzle))
               - Z_W'({1'b0, cfg.height});
    end
  end

  // Second stage: the three root arguments.
  always_comb begin
    base   = D_W'(ll_r) - D_W'(xx_r) - D_W'(yy_r);
    d1_nxt = base - D_W'(aa_r) - D_W'(bb_r) - (D_W'(ax_r) <<< 1) - (D_W'(by_r) <<< 1);
    d2_nxt = base - D_W'(aa_r) - D_W'(bb_r) + (D_W'(ax_r) <<< 1) - (D_W'(by_r) <<< 1);
    d3_nxt = base - D_W'(cc_r) - (D_W'(cy_r) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      arg_r.d[0] <= d1_nxt;
      arg_r.d[1] <= d2_nxt;
      arg_r.d[2] <= d3_nxt;
      arg_r.zp   <= zp1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = arg_r;

endmodule
`default_nettype wire

/* sv/dik_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module dik_sqrt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dik_pkg::dik_arg_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dik_pkg::dik_root_t       out_data
);
  import dik_pkg::*;

  // One result bit per stage, three towers side by side.
  logic [S_W-1:0]                 v_r;
  logic [S_W-1:0]                 rdy;
  logic [S_W-1:0][2:0][R_W-1:0]   rem_r, res_r;
  logic [S_W-1:0][2:0][R_W-1:0]   src_rem, src_res;
  logic [S_W-1:0][Z_W-1:0]        zp_r, src_zp;
  logic [S_W-1:0]                 unr_r, src_unr;
  logic [S_W-1:0]                 src_v;
  logic                           in_unr;

  // A negative argument marks the point out of reach; its root is not used.
  assign in_unr = in_data.d[0][D_W-1] | in_data.d[1][D_W-1] | in_data.d[2][D_W-1];

  genvar k, t;
  generate
    for (k = 0; k < S_W; k++) begin : g_stage
      localparam logic [R_W-1:0] BIT = R_W'(1) << (R_W - 2 - 2 * k);

      if (k == 0) begin : g_first
        for (t = 0; t < 3; t++) begin : g_src
          assign src_rem[k][t] = in_unr ? '0 : in_data.d[t][R_W-1:0];
          assign src_res[k][t] = '0;
        end
        assign src_zp[k]  = in_data.zp;
        assign src_unr[k] = in_unr;
        assign src_v[k]   = in_valid;
      end else begin : g_next
        assign src_rem[k] = rem_r[k-1];
        assign src_res[k] = res_r[k-1];
        assign src_zp[k]  = zp_r[k-1];
        assign src_unr[k] = unr_r[k-1];
        assign src_v[k]   = v_r[k-1];
      end

      if (k == S_W - 1) begin : g_last
        assign rdy[k] = !v_r[k] || out_ready;
      end else begin : g_mid
        assign rdy[k] = !v_r[k] || rdy[k+1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= src_v[k];
        end
      end

      // Restoring step: try the next bit of the root on each tower.
      for (t = 0; t < 3; t++) begin : g_lane
        logic [R_W-1:0] trial;
        assign trial = src_res[k][t] + BIT;
        always_ff @(posedge clk) begin
          if (rdy[k] && src_v[k]) begin
            if (src_rem[k][t] >= trial) begin
              rem_r[k][t] <= src_rem[k][t] - trial;
              res_r[k][t] <= (src_res[k][t] >> 1) + BIT;
            end else begin
              rem_r[k][t] <= src_rem[k][t];
              res_r[k][t] <= src_res[k][t] >> 1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && src_v[k]) begin
          zp_r[k]  <= src_zp[k];
          unr_r[k] <= src_unr[k];
        end
      end
    end

    for (t = 0; t < 3; t++) begin : g_out
      assign out_data.root[t] = res_r[S_W-1][t][S_W-1:0];
    end
  endgenerate

  assign in_ready     = rdy[0];
  assign out_valid    = v_r[S_W-1];
  assign out_data.zp  = zp_r[S_W-1];
  assign out_data.unr = unr_r[S_W-1];

endmodule
`default_nettype wire

/* sv/dik_scale.sv */
`timescale 1ns / 1ps
`default_nettype none
module dik_scale (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [dik_pkg::STEP_W-1:0]   steps,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire dik_pkg::dik_root_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0][dik_pkg::AX_W-1:0]     axis,
  output logic                              unreachable
);
  import dik_pkg::*;

  localparam logic signed [P_W-1:0] AX_MAX   = P_W'((64'sd1 <<< (AX_W - 1)) - 64'sd1);
  localparam logic signed [P_W-1:0] AX_MIN   = P_W'(-(64'sd1 <<< (AX_W - 1)));
  localparam logic signed [P_W-1:0] RND_ADD  = P_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [P_W-1:0] RND_NONE = '0;

  logic                         va_r, vb_r, vc_r;
  logic                         rdya, rdyb, rdyc;
  logic [2:0][E_W-1:0]          e_r;
  logic [2:0][P_W-1:0]          p_r;
  logic [2:0][AX_W-1:0]         ax_r;
  logic                         unra_r, unrb_r, unrc_r;
  logic signed [P_W-1:0]        q [3];

  assign rdyc     = !vc_r || out_ready;
  assign rdyb     = !vb_r || rdyc;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
      if (rdyc) vc_r <= vb_r;
    end
  end

  // Carriage height in millimetres: -z' - s.
  always_ff @(posedge clk) begin
    if (rdya && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i] <= -E_W'($signed(in_data.zp)) - E_W'(in_data.root[i]);
      end
      unra_r <= in_data.unr;
    end
  end

  // Scale to motor steps.
  always_ff @(posedge clk) begin
    if (rdyb && va_r) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= $signed(e_r[i]) * $signed({1'b0, steps});
      end
      unrb_r <= unra_r;
    end
  end

  // Drop the fraction toward zero and clamp to the axis range; an unreachable point gets zero axes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = ($signed(p_r[i]) + (p_r[i][P_W-1] ? RND_ADD : RND_NONE)) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyc && vb_r) begin
      for (int i = 0; i < 3; i++) begin
        if (unrb_r) begin
          ax_r[i] <= '0;
        end else if (q[i] > AX_MAX) begin
          ax_r[i] <= AX_MAX[AX_W-1:0];
        end else if (q[i] < AX_MIN) begin
          ax_r[i] <= AX_MIN[AX_W-1:0];
        end else begin
          ax_r[i] <= q[i][AX_W-1:0];
        end
      end
      unrc_r <= unrb_r;
    end
  end

  assign out_valid   = vc_r;
  assign axis        = ax_r;
  assign unreachable = unrc_r;

endmodule
`default_nettype wire

/* sv/delta_inverse_kinematics_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Inverse kinematics of a linear delta robot: each point (x, y, z in 1/256 mm)
// gives the three carriage positions in motor steps, truncated toward zero and
// clamped to 32 bits; a point out of reach raises tuser and zeroes the axes.
// The pipeline takes one transaction per cycle while the output is not stalled;
// a result passes two stages of products and sums, 21 stages of
// the bit-per-stage square root, and three stages of scaling and clamping, the
// last of which is the output register. Each stage holds its transaction while
// the next is full, so the stream stalls without loss. Configuration is to be
// written only while no transaction is in flight.
module delta_inverse_kinematics_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration writes.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [dik_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [dik_pkg::CFG_W-1:0]  cfg_data,
  // Points in.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [63:0]                in_tdata,   // pos_x, pos_y, pos_z, zero pad
  // Axes out.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [95:0]                     out_tdata,  // axis_one, axis_two, axis_three
  output logic [0:0]                      out_tuser   // unreachable
);
  import dik_pkg::*;

  dik_cfg_t             cfg_r;
  dik_arg_t             arg;
  dik_root_t            root;
  logic                 arg_valid, arg_ready, root_valid, root_ready;
  logic [2:0][AX_W-1:0] axis;
  logic                 unr;

  // Register file; a write to an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps  <= RST_STEPS;
      cfg_r.height <= RST_HEIGHT;
      cfg_r.arm    <= RST_ARM;
      cfg_r.nozzle <= '0;
      cfg_r.off_a  <= '0;
      cfg_r.off_b  <= '0;
      cfg_r.off_c  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEPS:  cfg_r.steps  <= cfg_data[STEP_W-1:0];
        REG_HEIGHT: cfg_r.height <= cfg_data[LEN_W-1:0];
        REG_ARM:    cfg_r.arm    <= cfg_data[LEN_W-1:0];
        REG_NOZZLE: cfg_r.nozzle <= cfg_data[LEN_W-1:0];
        REG_OFF_A:  cfg_r.off_a  <= cfg_data[OFF_W-1:0];
        REG_OFF_B:  cfg_r.off_b  <= cfg_data[OFF_W-1:0];
        REG_OFF_C:  cfg_r.off_c  <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  dik_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pos_x     (in_tdata[19:0]),
    .pos_y     (in_tdata[39:20]),
    .pos_z     (in_tdata[59:40]),
    .out_valid (arg_valid),
    .out_ready (arg_ready),
    .out_data  (arg)
  );

  dik_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (arg_valid),
    .in_ready  (arg_ready),
    .in_data   (arg),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root)
  );

  dik_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .steps       (cfg_r.steps),
    .in_valid    (root_valid),
    .in_ready    (root_ready),
    .in_data     (root),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .axis        (axis),
    .unreachable (unr)
  );

  assign out_tdata = {axis[2], axis[1], axis[0]};
  assign out_tuser = unr;

endmodule
`default_nettype wire

/* test/delta_inverse_kinematics_top_tb.sv */
`timescale 1ns / 1ps
module delta_inverse_kinematics_top_tb;
  import dik_pkg::*;

  // Result of one point: three axes and the out-of-reach flag.
  typedef struct {
    logic [31:0] ax1;
    logic [31:0] ax2;
    logic [31:0] ax3;
    logic        unr;
  } axes_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [0:0] out_tuser;

  // Local copy of the registers.
  logic [STEP_W-1:0] m_steps;
  logic [LEN_W-1:0] m_height, m_arm, m_nozzle;
  logic [OFF_W-1:0] m_a, m_b, m_c;

  axes_t expected_axes[$];
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  delta_inverse_kinematics_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("delta_inverse_kinematics_top test failed");
    $finish;
  end

  // Floor of the square root, bit by bit.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Carriage position in steps from shifted z and a root argument.
  function automatic logic [31:0] carriage_steps(longint zp, longint d);
    longint s, p, q;
    s = longint'(root_floor(d));
    p = (-zp - s) * longint'({54'd0, m_steps});
    if (p < 0) q = -((-p) >>> FRAC_BITS);
    else q = p >>> FRAC_BITS;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic axes_t solve_axes(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
    longint x, y, z, a, b, c, zp, base, d1, d2, d3;
    axes_t r;
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    a = longint'($signed(m_a));
    b = longint'($signed(m_b));
    c = longint'($signed(m_c));
    zp = z + longint'($signed(m_nozzle)) - longint'({45'd0, m_height});
    base = longint'({45'd0, m_arm}) * longint'({45'd0, m_arm}) - x * x - y * y;
    d1 = base - a * a - b * b - 2 * a * x - 2 * b * y;
    d2 = base - a * a - b * b + 2 * a * x - 2 * b * y;
    d3 = base - c * c - 2 * c * y;
    if (d1 < 0 || d2 < 0 || d3 < 0) begin
      r = '{32'd0, 32'd0, 32'd0, 1'b1};
    end else begin
      r.ax1 = carriage_steps(zp, d1);
      r.ax2 = carriage_steps(zp, d2);
      r.ax3 = carriage_steps(zp, d3);
      r.unr = 1'b0;
    end
    return r;
  endfunction

  // Receiver: random stall, and every accepted transaction is checked.
  always @(posedge clk) begin
    axes_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_axes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h %h", $time, out_tdata, out_tuser);
        end else begin
          e = expected_axes.pop_front();
          if (out_tdata !== {e.ax3, e.ax2, e.ax1} || out_tuser[0] !== e.unr) begin
            errors++;
            $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                     e.ax1, e.ax2, e.ax3, e.unr, out_tdata[31:0], out_tdata[63:32],
                     out_tdata[95:64], out_tuser[0]);
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one point, with a random idle gap first; valid stays up until the
  // next idle cycle or the next drain.
  task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, pz, py, px};
    expected_axes.push_back(solve_axes(px, py, pz));
    points_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Waits until every expected result has come, then lets the pipeline empty.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_axes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STEPS:  m_steps = val[STEP_W-1:0];
      REG_HEIGHT: m_height = val[LEN_W-1:0];
      REG_ARM:    m_arm = val[LEN_W-1:0];
      REG_NOZZLE: m_nozzle = val[LEN_W-1:0];
      REG_OFF_A:  m_a = val[OFF_W-1:0];
      REG_OFF_B:  m_b = val[OFF_W-1:0];
      REG_OFF_C:  m_c = val[OFF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_geometry(int st, int ht, int arm, int noz, int a, int b, int c);
    write_reg(REG_STEPS, CFG_W'(st));
    write_reg(REG_HEIGHT, CFG_W'(ht));
    write_reg(REG_ARM, CFG_W'(arm));
    write_reg(REG_NOZZLE, CFG_W'(noz));
    write_reg(REG_OFF_A, CFG_W'(a));
    write_reg(REG_OFF_B, CFG_W'(b));
    write_reg(REG_OFF_C, CFG_W'(c));
  endtask

  // A point mostly within reach of the arm, sometimes anywhere.
  task automatic send_random_point;
    int lim;
    lim = (m_arm > 4) ? int'(m_arm) / 2 : 1;
    if (lim > 524287) lim = 524287;
    if ($urandom_range(3) == 0)
      send_point(20'($urandom), 20'($urandom), 20'($urandom));
    else
      send_point(20'($urandom_range(2 * lim) - lim), 20'($urandom_range(2 * lim) - lim),
                 20'($urandom));
  endtask

  // Extremes of the coordinates, reach limits and scaling extremes.
  task automatic test_directed;
    send_point(20'd0, 20'd0, 20'd0);
    send_point(20'h80000, 20'd0, 20'd0);
    send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'd51200, 20'd0, 20'd0);
    send_point(20'd51201, 20'd0, 20'd0);
    send_point(20'd0, -20'sd51200, 20'h7FFFF);
    send_point(20'd1000, 20'd2000, 20'hFFFFF);
    drain();
    // Large scale and large lengths to reach the clamp.
    write_geometry(1023, 0, 524287, -262144, 0, 0, 0);
    send_point(20'd0, 20'd0, 20'h80000);
    send_point(20'd0, 20'd0, 20'h7FFFF);
    send_point(20'h55555, 20'h2AAAA, 20'h55555);
    drain();
    write_geometry(1023, 524287, 524287, 262143, 0, 0, 0);
    send_point(20'd0, 20'd0, 20'h7FFFF);
    send_point(20'd0, 20'd0, 20'h80000);
    drain();
    // Zero steps per mm, zero arm and non-zero offsets.
    write_geometry(0, 1000, 0, 5, 7, -9, 11);
    send_point(20'd0, 20'd0, 20'd0);
    send_point(20'd3, 20'd1, 20'd100);
    drain();
    write_geometry(1, 1, 1, 0, 524287, -524288, -524288);
    send_point(20'd1, 20'd0, 20'd0);
    send_point(20'h7FFFF, 20'h7FFFF, 20'h80000);
    drain();
    // An index beyond the list is ignored.
    write_reg(3'd7, 20'hFFFFF);
    send_point(20'd0, 20'd0, 20'd0);
    drain();
  endtask

  // Random geometry per phase, with each idling pattern.
  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_geometry($urandom_range(1023), $urandom_range(524287),
                     $urandom_range(20000, 524287), $urandom, $urandom_range(4000) - 2000,
                     $urandom_range(4000) - 2000, $urandom_range(4000) - 2000);
      for (int k = 0; k < 115; k++) begin
        send_random_point();
        // Hold off once until the pipeline is empty.
        if (ph == 2 && k == 50) drain();
      end
      drain();
    end
  endtask

  initial begin
    m_steps = RST_STEPS;
    m_height = RST_HEIGHT;
    m_arm = RST_ARM;
    m_nozzle = '0;
    m_a = '0;
    m_b = '0;
    m_c = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    $display("Covered %0d points, %0d results, reach limits, clamping and all registers.",
             points_sent, results_seen);
    $display("Idling phases: none, sender, receiver and both.");
    if (errors == 0) begin
      $display("delta_inverse_kinematics_top test passed");
    end else begin
      $display("delta_inverse_kinematics_top test failed");
    end
    $finish;
  end
endmodule
